>>> src/twa_pkg.sv
// Shared types, constants and helpers for the texel wrap address block.
// Used by texel_wrap_address and its port checker; depends on nothing else.
`timescale 1ns / 1ps

package twa_pkg;

  // Field and register widths.
  localparam int COORD_W = 16;
  localparam int DIM_W   = 13;
  localparam int DEPTH_W = 9;
  localparam int XY_W    = 12;
  localparam int Z_W     = 8;
  localparam int LIN_W   = 32;
  localparam int CFG_W   = 13;
  localparam int CFG_IDX_W = 2;

  // Largest sizes the address logic honors; larger register values saturate.
  localparam logic [DIM_W-1:0] MAX_DIM_XY = 13'd4096;
  localparam logic [DIM_W-1:0] MAX_DEPTH  = 13'd256;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WIDTH  = 2'd0,
    CFG_HEIGHT = 2'd1,
    CFG_DEPTH  = 2'd2,
    CFG_MODE   = 2'd3
  } cfg_idx_e;

  // Edge rules. Both mirror codes behave the same.
  typedef enum logic [1:0] {
    MODE_CLAMP      = 2'd0,
    MODE_REPEAT     = 2'd1,
    MODE_MIRROR     = 2'd2,
    MODE_MIRROR_ALT = 2'd3
  } wrap_mode_e;

  // Request payload.
  typedef struct packed {
    logic signed [COORD_W-1:0] coord_x;
    logic signed [COORD_W-1:0] coord_y;
    logic signed [COORD_W-1:0] coord_z;
  } twa_in_t;

  // Result payload.
  typedef struct packed {
    logic [XY_W-1:0]  wrapped_x;
    logic [XY_W-1:0]  wrapped_y;
    logic [Z_W-1:0]   wrapped_z;
    logic [LIN_W-1:0] linear_index;
  } twa_out_t;

  // A size register of zero acts as one, and a value above the limit saturates.
  function automatic logic [DIM_W-1:0] eff_size(input logic [DIM_W-1:0] raw,
                                                input logic [DIM_W-1:0] lim);
    logic [DIM_W-1:0] res;
    if (raw == '0) begin
      res = {{(DIM_W-1){1'b0}}, 1'b1};
    end else if (raw > lim) begin
      res = lim;
    end else begin
      res = raw;
    end
    return res;
  endfunction

endpackage

>>> src/texel_wrap_address.sv
// Top level of the texel wrap address block: edge rules and linear texel index.
// Depends on twa_pkg for payload types, register codes and the size helper.
`timescale 1ns / 1ps

// Folds a signed 3-D texel coordinate into the image by the configured edge rule
// (clamp, repeat, mirror) and returns the wrapped coordinates together with the
// linear index x + width*(y + height*z), taken modulo 2^32. One request enters
// per clock and one result leaves per clock when the output is not stalled. The
// request passes fourteen register stages: the input register, a magnitude
// stage, the per-axis remainder unit (a radix-4 pipeline of eight stages), a
// fold stage and three stages that form the index with two multipliers.
// Every stage is elastic, so bubbles are squeezed out while the output stalls.
// Configuration writes take effect at once and must be made while no request
// is in flight.
module texel_wrap_address
  import twa_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // Configuration write port.
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_wdata_i,
  // Request channel.
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  twa_in_t              in_req_i,
  // Result channel.
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output twa_out_t             out_req_o
);

  localparam int DIV_BITS   = 2;                   // remainder bits per stage
  localparam int DIV_STAGES = COORD_W / DIV_BITS;  // remainder stages
  localparam int NUM_AXES   = 3;
  // Pipeline stage numbers.
  localparam int P_IN   = 0;
  localparam int P_ABS  = 1;
  localparam int P_FOLD = P_ABS + DIV_STAGES + 1;
  localparam int P_MUL  = P_FOLD + 1;
  localparam int P_SUM  = P_MUL + 1;
  localparam int P_OUT  = P_SUM + 1;
  localparam int NS     = P_OUT + 1;
  localparam int HZ_W   = DIM_W + Z_W;
  localparam int SUM_W  = HZ_W + 1;
  localparam int PROD_W = DIM_W + SUM_W;

  // One axis moving through the remainder unit.
  typedef struct packed {
    logic signed [COORD_W-1:0] coord;  // original coordinate
    logic [COORD_W-1:0]        dvd;    // magnitude, shifted out MSB first
    logic [DIM_W-1:0]          rem;    // partial remainder
  } lane_t;

  typedef struct packed {
    logic [XY_W-1:0] x;
    logic [XY_W-1:0] y;
    logic [Z_W-1:0]  z;
  } xyz_t;

  // Two restoring divide steps: shift in one dividend bit, subtract if it fits.
  function automatic lane_t div_step(input lane_t l, input logic [DIM_W-1:0] d);
    lane_t          r;
    logic [DIM_W:0] t;
    r = l;
    for (int i = 0; i < DIV_BITS; i++) begin
      t     = {r.rem, r.dvd[COORD_W-1]};
      r.dvd = r.dvd << 1;
      if (t >= {1'b0, d}) begin
        t = t - {1'b0, d};
      end
      r.rem = t[DIM_W-1:0];
    end
    return r;
  endfunction

  // Configuration registers.
  logic [DIM_W-1:0]   width_q, height_q;
  logic [DEPTH_W-1:0] depth_q;
  wrap_mode_e         mode_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= {{(DIM_W-1){1'b0}}, 1'b1};
      height_q <= {{(DIM_W-1){1'b0}}, 1'b1};
      depth_q  <= {{(DEPTH_W-1){1'b0}}, 1'b1};
      mode_q   <= MODE_CLAMP;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_WIDTH:  width_q  <= cfg_wdata_i[DIM_W-1:0];
        CFG_HEIGHT: height_q <= cfg_wdata_i[DIM_W-1:0];
        CFG_DEPTH:  depth_q  <= cfg_wdata_i[DEPTH_W-1:0];
        CFG_MODE:   mode_q   <= wrap_mode_e'(cfg_wdata_i[1:0]);
        default:    ;
      endcase
    end
  end

  // Effective sizes and the divisor of each axis: the size for clamp and repeat, the
  // mirror period 2*size-2 otherwise. A one-texel mirror axis divides by one.
  logic [DIM_W-1:0] size_n  [NUM_AXES];
  logic [DIM_W-1:0] divisor [NUM_AXES];

  always_comb begin
    logic [DIM_W:0] period;
    size_n[0] = eff_size(width_q, MAX_DIM_XY);
    size_n[1] = eff_size(height_q, MAX_DIM_XY);
    size_n[2] = eff_size({{(DIM_W-DEPTH_W){1'b0}}, depth_q}, MAX_DEPTH);
    for (int ax = 0; ax < NUM_AXES; ax++) begin
      period = {size_n[ax], 1'b0} - {{(DIM_W-1){1'b0}}, 2'd2};
      if (mode_q == MODE_CLAMP || mode_q == MODE_REPEAT ||
          size_n[ax] == {{(DIM_W-1){1'b0}}, 1'b1}) begin
        divisor[ax] = size_n[ax];
      end else begin
        divisor[ax] = period[DIM_W-1:0];
      end
    end
  end

  // Elastic handshake: a stage takes new data when it is empty or drains.
  logic [NS-1:0] vld_q;
  logic [NS:0]   rdy;
  logic [NS-1:0] prev_vld;
  logic [NS-1:0] ld;

  always_comb begin
    rdy[NS] = !out_stall_i;
    for (int k = NS - 1; k >= 0; k--) begin
      rdy[k] = !vld_q[k] || rdy[k+1];
    end
  end

  assign prev_vld = {vld_q[NS-2:0], in_valid_i};
  assign ld       = rdy[NS-1:0] & prev_vld;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      for (int k = 0; k < NS; k++) begin
        if (rdy[k]) begin
          vld_q[k] <= prev_vld[k];
        end
      end
    end
  end

  assign in_stall_o  = !rdy[0];
  assign out_valid_o = vld_q[NS-1];

  // Input register.
  twa_in_t in_q;

  always_ff @(posedge clk_i) begin
    if (ld[P_IN]) begin
      in_q <= in_req_i;
    end
  end

  // Magnitudes enter the remainder unit.
  lane_t lane_q [DIV_STAGES+1][NUM_AXES];
  logic signed [COORD_W-1:0] in_coord [NUM_AXES];

  assign in_coord[0] = in_q.coord_x;
  assign in_coord[1] = in_q.coord_y;
  assign in_coord[2] = in_q.coord_z;

  always_ff @(posedge clk_i) begin
    if (ld[P_ABS]) begin
      for (int ax = 0; ax < NUM_AXES; ax++) begin
        lane_q[0][ax].coord <= in_coord[ax];
        lane_q[0][ax].dvd   <= in_coord[ax][COORD_W-1] ? -in_coord[ax] : in_coord[ax];
        lane_q[0][ax].rem   <= '0;
      end
    end
  end

  // Remainder pipeline, two bits per stage.
  for (genvar s = 1; s <= DIV_STAGES; s++) begin : g_div
    always_ff @(posedge clk_i) begin
      if (ld[P_ABS+s]) begin
        for (int ax = 0; ax < NUM_AXES; ax++) begin
          lane_q[s][ax] <= div_step(lane_q[s-1][ax], divisor[ax]);
        end
      end
    end
  end

  // Apply the edge rule to the remainder of each axis.
  logic [DIM_W-1:0] fold [NUM_AXES];

  always_comb begin
    lane_t            l;
    logic [DIM_W-1:0] n;
    logic [DIM_W-1:0] top;
    for (int ax = 0; ax < NUM_AXES; ax++) begin
      l   = lane_q[DIV_STAGES][ax];
      n   = size_n[ax];
      top = n - {{(DIM_W-1){1'b0}}, 1'b1};
      case (mode_q)
        MODE_CLAMP: begin
          if (l.coord[COORD_W-1]) begin
            fold[ax] = '0;
          end else if ($unsigned(l.coord) > {{(COORD_W-DIM_W){1'b0}}, top}) begin
            fold[ax] = top;
          end else begin
            fold[ax] = l.coord[DIM_W-1:0];
          end
        end
        MODE_REPEAT: begin
          // Floored modulo: a negative coordinate with a remainder wraps back.
          if (l.coord[COORD_W-1] && l.rem != '0) begin
            fold[ax] = n - l.rem;
          end else begin
            fold[ax] = l.rem;
          end
        end
        default: begin
          // Mirror: reflect the back half of the period.
          if (n == {{(DIM_W-1){1'b0}}, 1'b1}) begin
            fold[ax] = '0;
          end else if (l.rem >= n) begin
            fold[ax] = divisor[ax] - l.rem;
          end else begin
            fold[ax] = l.rem;
          end
        end
      endcase
    end
  end

  xyz_t fold_q;

  always_ff @(posedge clk_i) begin
    if (ld[P_FOLD]) begin
      fold_q.x <= fold[0][XY_W-1:0];
      fold_q.y <= fold[1][XY_W-1:0];
      fold_q.z <= fold[2][Z_W-1:0];
    end
  end

  // Index, first product: height * z.
  xyz_t            mul_q;
  logic [HZ_W-1:0] hz_q;

  always_ff @(posedge clk_i) begin
    if (ld[P_MUL]) begin
      mul_q <= fold_q;
      hz_q  <= HZ_W'(size_n[1]) * HZ_W'(fold_q.z);
    end
  end

  // Index, row sum: y + height * z.
  xyz_t             sum_q;
  logic [SUM_W-1:0] rows_q;

  always_ff @(posedge clk_i) begin
    if (ld[P_SUM]) begin
      sum_q  <= mul_q;
      rows_q <= SUM_W'(mul_q.y) + SUM_W'(hz_q);
    end
  end

  // Index, second product and final add into the output register.
  logic [PROD_W-1:0] prod;
  twa_out_t          out_q;

  assign prod = PROD_W'(size_n[0]) * PROD_W'(rows_q);

  always_ff @(posedge clk_i) begin
    if (ld[P_OUT]) begin
      out_q.wrapped_x    <= sum_q.x;
      out_q.wrapped_y    <= sum_q.y;
      out_q.wrapped_z    <= sum_q.z;
      out_q.linear_index <= LIN_W'(sum_q.x) + prod[LIN_W-1:0];
    end
  end

  assign out_req_o = out_q;

endmodule

>>> src/twa_checker.sv
// Port checker for texel_wrap_address, bound to every instance of it.
// Depends on twa_pkg for payload types, register codes and the size helper.
`timescale 1ns / 1ps

module twa_checker
  import twa_pkg::*;
(
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 cfg_we_i,
  input logic [CFG_IDX_W-1:0] cfg_idx_i,
  input logic [CFG_W-1:0]     cfg_wdata_i,
  input logic                 in_stall_o,
  input logic                 out_valid_o,
  input logic                 out_stall_i,
  input twa_out_t             out_req_o
);

  // Shadow copy of the size registers, taken from the write port.
  logic [DIM_W-1:0] width_q, height_q, depth_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= {{(DIM_W-1){1'b0}}, 1'b1};
      height_q <= {{(DIM_W-1){1'b0}}, 1'b1};
      depth_q  <= {{(DIM_W-1){1'b0}}, 1'b1};
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_WIDTH:  width_q  <= cfg_wdata_i[DIM_W-1:0];
        CFG_HEIGHT: height_q <= cfg_wdata_i[DIM_W-1:0];
        CFG_DEPTH:  depth_q  <= {{(DIM_W-DEPTH_W){1'b0}}, cfg_wdata_i[DEPTH_W-1:0]};
        default:    ;
      endcase
    end
  end

  logic [DIM_W-1:0] w_eff, h_eff, d_eff;
  logic [LIN_W-1:0] lin_expect;

  assign w_eff = eff_size(width_q, MAX_DIM_XY);
  assign h_eff = eff_size(height_q, MAX_DIM_XY);
  assign d_eff = eff_size(depth_q, MAX_DEPTH);
  assign lin_expect = LIN_W'(out_req_o.wrapped_x) + LIN_W'(w_eff) *
                      (LIN_W'(out_req_o.wrapped_y) +
                       LIN_W'(h_eff) * LIN_W'(out_req_o.wrapped_z));

  // A stalled result holds its value.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_req_o))
    else $error("stalled result changed");

  // The input side only backs up once the whole pipeline is full and stalled.
  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("request stalled while the pipeline had room");

  // Every wrapped coordinate lies inside the configured image.
  a_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ({1'b0, out_req_o.wrapped_x} < w_eff) &&
                    ({1'b0, out_req_o.wrapped_y} < h_eff) &&
                    ({5'b0, out_req_o.wrapped_z} < d_eff))
    else $error("wrapped coordinate outside the image");

  // The linear index matches the wrapped coordinates.
  a_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_req_o.linear_index == lin_expect)
    else $error("linear index does not match coordinates");

endmodule

bind texel_wrap_address twa_checker u_twa_checker (.*);

>>> sim/tb.sv
// Self-checking testbench for texel_wrap_address: directed and random requests
// are checked against an in-bench address predictor. Depends on twa_pkg and the RTL.
`timescale 1ns / 1ps

module tb;
  import twa_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 20;
  localparam int SEGMENTS       = 24;
  localparam int SEG_ITEMS      = 70;

  logic clk_i = 1'b0;
  logic rst_n = 1'b0;

  logic             cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx = '0;
  logic [CFG_W-1:0] cfg_wdata = '0;

  logic     in_valid = 1'b0;
  logic     in_stall_o;
  twa_in_t  in_req   = '0;
  logic     out_valid_o;
  logic     out_stall = 1'b0;
  twa_out_t out_req_o;

  // Shadow copy of the configuration registers.
  logic [DIM_W-1:0]   width_reg  = 13'd1;
  logic [DIM_W-1:0]   height_reg = 13'd1;
  logic [DEPTH_W-1:0] depth_reg  = 9'd1;
  wrap_mode_e         mode_reg   = MODE_CLAMP;

  twa_in_t  coord_q[$];
  twa_out_t wrapped_due_q[$];

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int err_count      = 0;
  int idle_cycles    = 0;

  texel_wrap_address u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall_o),
    .in_req_i    (in_req),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall),
    .out_req_o   (out_req_o)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Size register as the address logic sees it: zero acts as one, large values saturate.
  function automatic longint unsigned eff_dim(logic [DIM_W-1:0] raw, int unsigned lim);
    longint unsigned r;
    if (raw == 0) begin
      r = 64'd1;
    end else if (raw > lim) begin
      r = 64'(lim);
    end else begin
      r = 64'(raw);
    end
    return r;
  endfunction

  // Folds one signed axis coordinate into 0..n-1 by the edge rule.
  function automatic longint unsigned fold_coord(logic signed [COORD_W-1:0] c,
                                                 longint unsigned n, wrap_mode_e mode);
    longint cv;
    longint nv;
    longint period;
    longint mag;
    longint r;
    cv = longint'(c);
    nv = n;
    case (mode)
      MODE_CLAMP: begin
        if (cv < 0) begin
          r = 0;
        end else if (cv > nv - 1) begin
          r = nv - 1;
        end else begin
          r = cv;
        end
      end
      MODE_REPEAT: begin
        r = cv % nv;
        if (r < 0) r = r + nv;
      end
      default: begin
        // Both mirror codes reflect with period 2n-2; a single texel axis gives 0.
        if (nv == 1) begin
          r = 0;
        end else begin
          period = 2 * nv - 2;
          mag = (cv < 0) ? -cv : cv;
          r = mag % period;
          if (r >= nv) r = period - r;
        end
      end
    endcase
    return longint'(r);
  endfunction

  // Wrapped coordinates and linear texel index for one request.
  function automatic twa_out_t wrap_texel(twa_in_t req);
    longint unsigned w, h, d, x, y, z, lin;
    twa_out_t res;
    w = eff_dim(width_reg, 32'(MAX_DIM_XY));
    h = eff_dim(height_reg, 32'(MAX_DIM_XY));
    d = eff_dim(DIM_W'(depth_reg), 32'(MAX_DEPTH));
    x = fold_coord(req.coord_x, w, mode_reg);
    y = fold_coord(req.coord_y, h, mode_reg);
    z = fold_coord(req.coord_z, d, mode_reg);
    lin = x + w * (y + h * z);
    res.wrapped_x    = x[XY_W-1:0];
    res.wrapped_y    = y[XY_W-1:0];
    res.wrapped_z    = z[Z_W-1:0];
    res.linear_index = lin[LIN_W-1:0];
    return res;
  endfunction

  task automatic report_field(string fname, longint unsigned exp_v, longint unsigned act_v);
    if (exp_v != act_v) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, fname, exp_v, act_v);
      err_count++;
    end
  endtask

  // Driver: presents queued requests, holding each one while it is stalled.
  always @(posedge clk_i) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall_o) begin
        wrapped_due_q.push_back(wrap_texel(in_req));
      end
      if (!in_valid || !in_stall_o) begin
        if (coord_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          in_req   <= coord_q.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks each accepted result against the oldest prediction.
  always @(posedge clk_i) begin
    twa_out_t due;
    if (rst_n) begin
      if (out_valid_o && !out_stall) begin
        if (wrapped_due_q.size() == 0) begin
          $display("%0t: result with no request pending, expected none, actual %0h",
                   $time, out_req_o);
          err_count++;
        end else begin
          due = wrapped_due_q.pop_front();
          report_field("wrapped_x", 64'(due.wrapped_x), 64'(out_req_o.wrapped_x));
          report_field("wrapped_y", 64'(due.wrapped_y), 64'(out_req_o.wrapped_y));
          report_field("wrapped_z", 64'(due.wrapped_z), 64'(out_req_o.wrapped_z));
          report_field("linear_index", 64'(due.linear_index),
                       64'(out_req_o.linear_index));
        end
      end
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // Watchdog: the run ends if work is outstanding and nothing moves for too long.
  always @(posedge clk_i) begin
    if ((coord_q.size() > 0 || in_valid || wrapped_due_q.size() > 0) &&
        !(in_valid && !in_stall_o) && !(out_valid_o && !out_stall)) begin
      idle_cycles <= idle_cycles + 1;
    end else begin
      idle_cycles <= 0;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  task automatic write_reg(cfg_idx_e idx, logic [CFG_W-1:0] data);
    @(posedge clk_i);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= data;
    case (idx)
      CFG_WIDTH:  width_reg  = data[DIM_W-1:0];
      CFG_HEIGHT: height_reg = data[DIM_W-1:0];
      CFG_DEPTH:  depth_reg  = data[DEPTH_W-1:0];
      CFG_MODE:   mode_reg   = wrap_mode_e'(data[1:0]);
      default: ;
    endcase
  endtask

  task automatic write_config(logic [CFG_W-1:0] w, logic [CFG_W-1:0] h,
                              logic [CFG_W-1:0] d, logic [CFG_W-1:0] m);
    write_reg(CFG_WIDTH, w);
    write_reg(CFG_HEIGHT, h);
    write_reg(CFG_DEPTH, d);
    write_reg(CFG_MODE, m);
    @(posedge clk_i);
    cfg_we <= 1'b0;
  endtask

  task automatic push_coord(int x, int y, int z);
    twa_in_t req;
    req.coord_x = x[COORD_W-1:0];
    req.coord_y = y[COORD_W-1:0];
    req.coord_z = z[COORD_W-1:0];
    coord_q.push_back(req);
  endtask

  // Waits until every queued request is in and every result is out.
  task automatic wait_drained();
    while (coord_q.size() > 0 || in_valid || wrapped_due_q.size() > 0) @(posedge clk_i);
  endtask

  // Random size value, mostly small, sometimes at or past the limits.
  function automatic logic [CFG_W-1:0] rand_dim(int unsigned lim);
    int unsigned r;
    case ($urandom_range(9))
      0, 1, 2, 3, 4, 5: r = $urandom_range(1, 16);
      6: r = $urandom_range(17, lim);
      default: begin
        case ($urandom_range(5))
          0: r = 0;
          1: r = 1;
          2: r = lim - 1;
          3: r = lim;
          4: r = lim + 1;
          default: r = 2 * lim - 1;
        endcase
      end
    endcase
    return r[CFG_W-1:0];
  endfunction

  // Random coordinate: mostly near the image, some full range, some edge values.
  function automatic int rand_coord(longint unsigned n);
    int nv;
    int r;
    nv = int'(n);
    case ($urandom_range(9))
      0: begin
        case ($urandom_range(7))
          0: r = -32768;
          1: r = 32767;
          2: r = 0;
          3: r = -1;
          4: r = nv - 1;
          5: r = nv;
          6: r = -nv;
          default: r = 2 * nv - 2;
        endcase
      end
      1, 2: r = int'($urandom_range(0, 65535)) - 32768;
      default: r = int'($urandom_range(0, 6 * nv + 4)) - (3 * nv + 2);
    endcase
    return r;
  endfunction

  initial begin
    logic [CFG_W-1:0] dep;
    longint unsigned we, he, de;
    repeat (11) @(posedge clk_i);
    rst_n <= 1'b1;
    @(posedge clk_i);

    // Reset configuration: a single texel, clamp.
    push_coord(32767, -32768, -1);
    push_coord(-32768, 32767, 0);
    wait_drained();

    // Each edge rule on a small image, with extreme and edge coordinates.
    for (int m = 0; m < 4; m++) begin
      write_config(13'd7, 13'd4, 13'd3, CFG_W'(m));
      push_coord(32767, -32768, -1);
      push_coord(-32768, 32767, 0);
      push_coord(6, 3, 2);
      push_coord(7, -5, 4);
      wait_drained();
    end

    // Zero sizes act as one; mirror on a single texel gives 0.
    write_config(13'd0, 13'd1, 13'd0, CFG_W'(MODE_MIRROR_ALT));
    push_coord(-12345, 23456, 1);
    push_coord(1, -1, 32767);
    wait_drained();

    // Oversized registers saturate; upper depth data bits are dropped.
    write_config(13'h1FFF, 13'd4097, 13'h1FFF, CFG_W'(MODE_REPEAT));
    push_coord(-1, 4096, -257);
    push_coord(32767, -32768, 255);
    wait_drained();

    // Random configurations, each under one idling pattern.
    for (int seg = 0; seg < SEGMENTS; seg++) begin
      case (seg % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 61; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 61; end
        default: begin send_idle_pct = 15; recv_stall_pct = 15; end
      endcase
      dep = rand_dim(32'(MAX_DEPTH));
      dep[CFG_W-1:DEPTH_W] = (CFG_W-DEPTH_W)'($urandom_range(0, 15));
      write_config(rand_dim(32'(MAX_DIM_XY)), rand_dim(32'(MAX_DIM_XY)), dep,
                   CFG_W'($urandom_range(0, 8191)));
      we = eff_dim(width_reg, 32'(MAX_DIM_XY));
      he = eff_dim(height_reg, 32'(MAX_DIM_XY));
      de = eff_dim(DIM_W'(depth_reg), 32'(MAX_DEPTH));
      for (int k = 0; k < SEG_ITEMS; k++) begin
        push_coord(rand_coord(we), rand_coord(he), rand_coord(de));
      end
      wait_drained();
    end

    // Let any stray result show up before the verdict.
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (err_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

>>> sim.f
src/twa_pkg.sv
src/texel_wrap_address.sv
src/twa_checker.sv
sim/tb.sv
